### rtl/lbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbd_pkg: shared types and constants for the letterbox bar detector
// Field widths, register indexes and limits used by the detector logic.
// ----------------------------------------------------------------------------
package lbd_pkg;

	localparam int unsigned SUM_W   = 22;   // line sum and threshold
	localparam int unsigned CNT_W   = 13;   // line count, heights
	localparam int unsigned IDX_W   = 12;   // line indexes
	localparam int unsigned PX_W    = 10;   // sum of three colour bytes
	localparam int unsigned REG_W   = 22;   // widest config register
	localparam int unsigned RIDX_W  = 2;
	localparam int unsigned IN_W    = 24;   // s_axis_tdata width
	localparam int unsigned OUT_W   = 56;   // m_axis_tdata width

	localparam logic [CNT_W-1:0] MAX_HEIGHT = 13'd4096;
	localparam logic [SUM_W-1:0] SUM_MAX    = {SUM_W{1'b1}};
	localparam logic [IDX_W-1:0] IDX_MAX    = {IDX_W{1'b1}};

	localparam logic [RIDX_W-1:0] REG_LINE_THRESHOLD    = 2'd0;
	localparam logic [RIDX_W-1:0] REG_TOP_SCAN_LINES    = 2'd1;
	localparam logic [RIDX_W-1:0] REG_BOTTOM_SCAN_START = 2'd2;

	localparam logic [SUM_W-1:0] THRESHOLD_RST = '0;
	localparam logic [CNT_W-1:0] TOP_SCAN_RST  = 13'd4096;
	localparam logic [IDX_W-1:0] BOT_START_RST = '0;

	typedef struct packed {
		logic             crop_needed;
		logic [CNT_W-1:0] cropped_height;
		logic [CNT_W-1:0] frame_height;
		logic [IDX_W-1:0] bottom_line;
		logic [IDX_W-1:0] top_line;
	} result_t;

endpackage
`default_nettype wire

### rtl/letterbox_bar_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// letterbox_bar_detector: finds the top and bottom picture lines of a frame
// Sums each line of a raster pixel stream, tracks the first and last
// non-black lines and reports the crop window on the frame's last pixel.
// ----------------------------------------------------------------------------
// A frame's result passes from the input register to the output register,
// which takes it once any earlier result there has been accepted.
// One pixel per cycle, but a frame's last pixel stalls the input while the
// output register is still full; the output register frees the input side.
// Reset clears all frame state and loads register defaults (threshold 0,
// top scan 4096 lines, bottom scan start 0). Frame state clears after each result.
module letterbox_bar_detector (
	input  wire                        clk,
	input  wire                        arst_n,
	// configuration writes
	input  wire                        cfg_wr_en,
	input  wire [lbd_pkg::RIDX_W-1:0]  cfg_index,
	input  wire [lbd_pkg::REG_W-1:0]   cfg_data,
	// pixel stream
	input  wire                        s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire [lbd_pkg::IN_W-1:0]    s_axis_tdata,   // chan_a, chan_b, chan_c
	input  wire                        s_axis_tlast,   // end_of_frame
	input  wire                        s_axis_tuser,   // end_of_line
	// frame result
	output logic                       m_axis_tvalid,
	input  wire                        m_axis_tready,
	output logic [lbd_pkg::OUT_W-1:0]  m_axis_tdata    // top_line, bottom_line,
	                                                    // frame_height,
	                                                    // cropped_height,
	                                                    // crop_needed, zero pad
);
	import lbd_pkg::*;

	// configuration registers
	logic [SUM_W-1:0] threshold_q;
	logic [CNT_W-1:0] top_scan_q;
	logic [IDX_W-1:0] bot_start_q;

	// input stage
	logic             valid_s1;
	logic [PX_W-1:0]  px_s1;
	logic             eol_s1;
	logic             eof_s1;

	// frame state
	logic [SUM_W-1:0] line_sum_q;
	logic [CNT_W-1:0] line_count_q;
	logic             top_found_q;
	logic [IDX_W-1:0] top_index_q;
	logic             bot_found_q;
	logic [IDX_W-1:0] bot_index_q;

	// output register
	logic             out_valid_q;
	result_t          out_q;

	logic             advance;
	logic             in_fire;
	logic [SUM_W:0]   sum_wide;
	logic [SUM_W-1:0] sum_sat;
	logic             line_end;
	logic             line_used;
	logic             lit;
	logic [CNT_W-1:0] tsl;
	logic             top_hit;
	logic             bot_hit;
	logic [CNT_W-1:0] count_nx;
	logic             top_found_nx;
	logic [IDX_W-1:0] top_index_nx;
	logic             bot_found_nx;
	logic [IDX_W-1:0] bot_index_nx;
	logic [CNT_W-1:0] lim;
	logic [IDX_W-1:0] top_res;
	logic [IDX_W-1:0] bot_res;
	logic [CNT_W-1:0] cropped;
	result_t          res;

	assign advance       = valid_s1 && (!eof_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			top_scan_q  <= TOP_SCAN_RST;
			bot_start_q <= BOT_START_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_LINE_THRESHOLD:    threshold_q <= cfg_data[SUM_W-1:0];
				REG_TOP_SCAN_LINES:    top_scan_q  <= cfg_data[CNT_W-1:0];
				REG_BOTTOM_SCAN_START: bot_start_q <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_s1  <= PX_W'(s_axis_tdata[7:0]) + PX_W'(s_axis_tdata[15:8])
			        + PX_W'(s_axis_tdata[23:16]);
			eol_s1 <= s_axis_tuser;
			eof_s1 <= s_axis_tlast;
		end
	end

	// line update
	always_comb begin
		sum_wide  = {1'b0, line_sum_q} + (SUM_W+1)'(px_s1);
		sum_sat   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
		line_end  = eol_s1 || eof_s1;
		line_used = line_end && (line_count_q < MAX_HEIGHT);
		lit       = sum_sat >= threshold_q;
		tsl       = (top_scan_q == '0) ? CNT_W'(1) : top_scan_q;
		top_hit   = line_used && lit && !top_found_q && (line_count_q < tsl);
		bot_hit   = line_used && lit && (line_count_q > CNT_W'(bot_start_q));

		count_nx     = line_used ? line_count_q + CNT_W'(1) : line_count_q;
		top_found_nx = top_found_q || top_hit;
		top_index_nx = top_hit ? line_count_q[IDX_W-1:0] : top_index_q;
		bot_found_nx = bot_found_q || bot_hit;
		bot_index_nx = bot_hit ? line_count_q[IDX_W-1:0] : bot_index_q;
	end

	// frame result from the updated state
	always_comb begin
		lim = (tsl < count_nx) ? tsl : count_nx;
		if (top_found_nx) begin
			top_res = top_index_nx;
		end else if (lim == '0) begin
			top_res = '0;
		end else begin
			top_res = IDX_W'(lim - CNT_W'(1));
		end
		if (bot_found_nx) begin
			bot_res = bot_index_nx;
		end else if (bot_start_q == IDX_MAX) begin
			bot_res = IDX_MAX;
		end else begin
			bot_res = bot_start_q + IDX_W'(1);
		end
		cropped = (bot_res >= top_res)
		        ? CNT_W'(bot_res) - CNT_W'(top_res) + CNT_W'(1) : '0;

		res.top_line       = top_res;
		res.bottom_line    = bot_res;
		res.frame_height   = count_nx;
		res.cropped_height = cropped;
		res.crop_needed    = cropped != count_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_sum_q   <= '0;
			line_count_q <= '0;
			top_found_q  <= 1'b0;
			top_index_q  <= '0;
			bot_found_q  <= 1'b0;
			bot_index_q  <= '0;
		end else if (advance) begin
			if (eof_s1) begin
				// drop frame state once the result is captured
				line_sum_q   <= '0;
				line_count_q <= '0;
				top_found_q  <= 1'b0;
				top_index_q  <= '0;
				bot_found_q  <= 1'b0;
				bot_index_q  <= '0;
			end else begin
				line_sum_q   <= line_end ? '0 : sum_sat;
				line_count_q <= count_nx;
				top_found_q  <= top_found_nx;
				top_index_q  <= top_index_nx;
				bot_found_q  <= bot_found_nx;
				bot_index_q  <= bot_index_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && eof_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eof_s1) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_W-$bits(result_t))'(0), out_q};

endmodule
`default_nettype wire

### tb/tb_letterbox_bar_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_letterbox_bar_detector: self-checking bench for the letterbox detector
// Streams raster frames under several register settings with random source
// gaps and sink stalls. A scoreboard tracks line sums and crop bounds to
// predict each frame's crop window, which is checked field by field.
// ----------------------------------------------------------------------------
module tb_letterbox_bar_detector;
	import lbd_pkg::*;

	localparam int STUCK_LIMIT = 2000;
	localparam int RANDOM_PIXELS = 1400;
	localparam int QUIET_FROM = 1150;

	class crop_window_tracker;
		logic [SUM_W-1:0] threshold;
		logic [CNT_W-1:0] top_scan;
		logic [IDX_W-1:0] bottom_start;
		logic [SUM_W-1:0] line_sum;
		logic [CNT_W-1:0] line_count;
		bit               top_found;
		bit               bottom_found;
		logic [IDX_W-1:0] top_index;
		logic [IDX_W-1:0] bottom_index;
		result_t          pending_windows[$];
		int unsigned      errors;

		function void clear_frame();
			line_sum = '0;
			line_count = '0;
			top_found = 1'b0;
			bottom_found = 1'b0;
			top_index = '0;
			bottom_index = '0;
		endfunction

		function void reset_regs();
			threshold = THRESHOLD_RST;
			top_scan = TOP_SCAN_RST;
			bottom_start = BOT_START_RST;
			clear_frame();
		endfunction

		function void write_reg(logic [RIDX_W-1:0] idx, logic [REG_W-1:0] value);
			case (idx)
			REG_LINE_THRESHOLD: begin
				threshold = value[SUM_W-1:0];
			end
			REG_TOP_SCAN_LINES: begin
				top_scan = value[CNT_W-1:0];
			end
			REG_BOTTOM_SCAN_START: begin
				bottom_start = value[IDX_W-1:0];
			end
			default: begin
			end
			endcase
		endfunction

		// Note one accepted pixel; a frame's last pixel queues its crop window.
		function void note_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c, bit eol, bit eof);
			int unsigned sum, scan, lim, top, bot, cropped, height;
			bit          lit;
			result_t     w;
			scan = (top_scan == 0) ? 1 : 32'(top_scan);
			sum = 32'(line_sum) + 32'(a) + 32'(b) + 32'(c);
			if (sum > 32'(SUM_MAX)) begin
				sum = 32'(SUM_MAX);
			end
			line_sum = SUM_W'(sum);
			if (eol || eof) begin
				// lines past the height limit are neither examined nor counted
				if (line_count < MAX_HEIGHT) begin
					lit = line_sum >= threshold;
					if (lit && !top_found && 32'(line_count) < scan) begin
						top_found = 1'b1;
						top_index = line_count[IDX_W-1:0];
					end
					if (lit && 32'(line_count) > 32'(bottom_start)) begin
						bottom_found = 1'b1;
						bottom_index = line_count[IDX_W-1:0];
					end
					line_count = line_count + 1'b1;
				end
				line_sum = '0;
			end
			if (!eof) begin
				return;
			end
			height = 32'(line_count);
			if (top_found) begin
				top = 32'(top_index);
			end else begin
				lim = (scan < height) ? scan : height;
				top = (lim == 0) ? 0 : lim - 1;
				if (top > 32'(IDX_MAX)) begin
					top = 32'(IDX_MAX);
				end
			end
			if (bottom_found) begin
				bot = 32'(bottom_index);
			end else begin
				bot = 32'(bottom_start) + 1;
				if (bot > 32'(IDX_MAX)) begin
					bot = 32'(IDX_MAX);
				end
			end
			cropped = (bot >= top) ? bot - top + 1 : 0;
			w.top_line = IDX_W'(top);
			w.bottom_line = IDX_W'(bot);
			w.frame_height = CNT_W'(height);
			w.cropped_height = CNT_W'(cropped);
			w.crop_needed = (cropped != height);
			pending_windows.push_back(w);
			clear_frame();
		endfunction

		function void check_window(result_t got);
			result_t want;
			string   diffs;
			if (pending_windows.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: result with no frame pending: top %0d bot %0d h %0d crop %0d flag %0d",
						$time, got.top_line, got.bottom_line, got.frame_height,
						got.cropped_height, got.crop_needed);
				end
				return;
			end
			want = pending_windows.pop_front();
			diffs = "";
			if (got.top_line != want.top_line) begin
				diffs = {diffs, " top_line"};
			end
			if (got.bottom_line != want.bottom_line) begin
				diffs = {diffs, " bottom_line"};
			end
			if (got.frame_height != want.frame_height) begin
				diffs = {diffs, " frame_height"};
			end
			if (got.cropped_height != want.cropped_height) begin
				diffs = {diffs, " cropped_height"};
			end
			if (got.crop_needed != want.crop_needed) begin
				diffs = {diffs, " crop_needed"};
			end
			if (diffs != "") begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: crop window mismatch in%s", $time, diffs);
					$display("  expected top %0d bot %0d h %0d crop %0d flag %0d",
						want.top_line, want.bottom_line, want.frame_height,
						want.cropped_height, want.crop_needed);
					$display("  actual   top %0d bot %0d h %0d crop %0d flag %0d",
						got.top_line, got.bottom_line, got.frame_height,
						got.cropped_height, got.crop_needed);
				end
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [RIDX_W-1:0] cfg_index;
	logic [REG_W-1:0]  cfg_data;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata;   // chan_a, chan_b, chan_c
	logic              s_axis_tlast;   // end_of_frame
	logic              s_axis_tuser;   // end_of_line
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;   // top_line, bottom_line, frame_height,
	                                   // cropped_height, crop_needed, zero pad

	crop_window_tracker tracker = new();
	int  sent_pixels;
	int  sink_stall;
	int  stuck_cycles;
	bit  src_idle_on;
	bit  sink_idle_on;

	letterbox_bar_detector dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sink side: random stall bursts while enabled
	always @(negedge clk) begin
		if (sink_stall > 0) begin
			m_axis_tready <= 1'b0;
			sink_stall--;
		end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
			m_axis_tready <= 1'b0;
			sink_stall = $urandom_range(0, 9);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// monitor both streams; a result always belongs to an earlier frame
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				tracker.check_window(result_t'(m_axis_tdata[$bits(result_t)-1:0]));
			end
			if (s_axis_tvalid && s_axis_tready) begin
				tracker.note_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
					s_axis_tuser, s_axis_tlast);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
		end
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
			$display("tb_letterbox_bar_detector NOT OK");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c, bit eol, bit eof);
		int gap;
		if (src_idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 10);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {c, b, a};
		s_axis_tuser <= eol;
		s_axis_tlast <= eof;
		do @(posedge clk); while (!s_axis_tready);
		sent_pixels++;
		@(negedge clk);
	endtask

	// Lines flagged in lit_map get bright pixels, the others near-black ones.
	task automatic send_frame(int width, int lines, logic [31:0] lit_map, bit full_swing,
			bit last_eol);
		logic [7:0] ch[3];
		bit         lit;
		bit         eol;
		bit         eof;
		for (int l = 0; l < lines; l++) begin
			lit = lit_map[l % 32];
			for (int p = 0; p < width; p++) begin
				for (int k = 0; k < 3; k++) begin
					if (full_swing) begin
						ch[k] = lit ? 8'hFF : 8'h00;
					end else begin
						ch[k] = lit ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
					end
				end
				eof = (l == lines - 1) && (p == width - 1);
				eol = (p == width - 1) && (!eof || last_eol);
				send_pixel(ch[0], ch[1], ch[2], eol, eof);
			end
		end
	endtask

	// Hold off until every frame's window has come back and the pipe is empty.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending_windows.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic configure(logic [REG_W-1:0] th, logic [REG_W-1:0] ts, logic [REG_W-1:0] bs);
		logic [RIDX_W-1:0] idxs[3];
		logic [REG_W-1:0]  vals[3];
		idxs = '{REG_LINE_THRESHOLD, REG_TOP_SCAN_LINES, REG_BOTTOM_SCAN_START};
		vals = '{th, ts, bs};
		for (int k = 0; k < 3; k++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idxs[k];
			cfg_data <= vals[k];
			tracker.write_reg(idxs[k], vals[k]);
			@(negedge clk);
		end
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_frames(int budget);
		int          first;
		int          width;
		int          lines;
		int          top_black;
		int          bot_black;
		logic [31:0] lit_map;
		first = sent_pixels;
		while (sent_pixels - first < budget) begin
			width = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
			lines = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 32) : $urandom_range(1, 12);
			case ($urandom_range(0, 3))
			0: begin
				// letterbox shape: black bars above and below a lit picture
				top_black = $urandom_range(0, lines / 2);
				bot_black = $urandom_range(0, lines / 2);
				lit_map = '0;
				for (int l = top_black; l < lines - bot_black; l++) begin
					lit_map[l] = 1'b1;
				end
			end
			1: begin
				lit_map = $urandom();
			end
			2: begin
				lit_map = '0;
			end
			default: begin
				lit_map = '1;
			end
			endcase
			send_frame(width, lines, lit_map, $urandom_range(0, 4) == 0, $urandom_range(0, 3) != 0);
		end
	endtask

	initial begin
		logic [REG_W-1:0] th;
		logic [REG_W-1:0] ts;
		logic [REG_W-1:0] bs;
		int               random_start;
		bit               quiet;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		sent_pixels = 0;
		sink_stall = 0;
		stuck_cycles = 0;
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		tracker.reset_regs();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset defaults: zero threshold lights every line
		send_frame(1, 1, '1, 1'b1, 1'b0);
		send_frame(2, 3, 32'b010, 1'b1, 1'b1);
		drain();
		// zero top scan (treated as one line), bottom start at the highest index
		configure(22'd1530, 22'd0, 22'd4095);
		send_frame(2, 4, 32'b0110, 1'b1, 1'b1);
		drain();
		configure(22'd1, 22'd1, 22'd1);
		send_frame(1, 4, 32'b1001, 1'b1, 1'b0);
		drain();
		// threshold out of reach for short lines, widest top scan
		configure(22'd4177920, 22'd8191, 22'd2);
		send_frame(3, 2, '1, 1'b1, 1'b1);
		drain();

		random_start = sent_pixels;
		while (sent_pixels - random_start < RANDOM_PIXELS) begin
			quiet = (sent_pixels - random_start) >= QUIET_FROM;
			src_idle_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
			sink_idle_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 5))
			0: begin
				th = 22'd0;
			end
			1: begin
				th = 22'd4177920;
			end
			2: begin
				th = REG_W'($urandom_range(0, 6000));
			end
			default: begin
				th = REG_W'($urandom_range(40, 400));
			end
			endcase
			case ($urandom_range(0, 4))
			0: begin
				ts = 22'd0;
			end
			1: begin
				ts = 22'd4096;
			end
			2: begin
				ts = 22'd8191;
			end
			default: begin
				ts = REG_W'($urandom_range(1, 12));
			end
			endcase
			case ($urandom_range(0, 3))
			0: begin
				bs = 22'd0;
			end
			1: begin
				bs = 22'd4095;
			end
			default: begin
				bs = REG_W'($urandom_range(0, 14));
			end
			endcase
			configure(th, ts, bs);
			random_frames($urandom_range(100, 200));
			drain();
		end

		repeat (10) @(negedge clk);
		if (tracker.errors == 0 && tracker.pending_windows.size() == 0) begin
			$display("tb_letterbox_bar_detector OK");
		end else begin
			$display("tb_letterbox_bar_detector NOT OK");
		end
		$finish;
	end

endmodule
